/* rtl/sorted_integer_set_macros.svh */
// Assertion macros used by the sorted integer set port checker.
`ifndef SORTED_INTEGER_SET_MACROS_SVH
`define SORTED_INTEGER_SET_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ssi_pkg.sv */
// Package of the sorted integer set: sizes, command codes, state and control types.
package ssi_pkg;

  localparam int unsigned CAPACITY   = 32;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned CountOutW  = 6;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2
  } command_e;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic lookup;
    logic update;
    logic do_insert;
    logic do_delete;
  } cell_ctrl_t;

endpackage

/* rtl/ssi_ifs.sv */
// Handshake interfaces for the command and result channels.
interface ssi_in_if;
  logic                                valid;
  logic                                ready;
  logic [ssi_pkg::CmdW-1:0]            command;
  logic signed [ssi_pkg::ValueW-1:0]   item_value;

  modport source (output valid, output command, output item_value, input ready);
  modport sink   (input valid, input command, input item_value, output ready);
endinterface

interface ssi_out_if;
  logic                                valid;
  logic                                ready;
  logic                                was_present;
  logic [ssi_pkg::CountOutW-1:0]       element_count;
  logic                                insert_dropped;

  modport source (output valid, output was_present, output element_count,
                  output insert_dropped, input ready);
  modport sink   (input valid, input was_present, input element_count,
                  input insert_dropped, output ready);
endinterface

/* rtl/ssi_cell.sv */
// One cell of the sorted entry row: compare against the key, then shift or load.
module ssi_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 6
) (
  input  logic                               clk_i,
  input  ssi_pkg::cell_ctrl_t                ctrl_i,
  input  logic [CntW-1:0]                    count_i,
  input  logic signed [ssi_pkg::ValueW-1:0]  cmp_key_i,
  input  logic signed [ssi_pkg::ValueW-1:0]  ins_key_i,
  input  logic signed [ssi_pkg::ValueW-1:0]  left_entry_i,
  input  logic                               left_lt_i,
  input  logic signed [ssi_pkg::ValueW-1:0]  right_entry_i,
  output logic signed [ssi_pkg::ValueW-1:0]  entry_o,
  output logic                               lt_o,
  output logic                               eq_o
);

  logic signed [ssi_pkg::ValueW-1:0] entry_q;
  logic                              lt_q;
  logic                              eq_q;
  logic                              occupied;

  assign occupied = count_i > CntW'(Index);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.lookup) begin
      lt_q <= occupied && (entry_q < cmp_key_i);
      eq_q <= occupied && (entry_q == cmp_key_i);
    end
    if (ctrl_i.update && !lt_q) begin
      if (ctrl_i.do_insert) begin
        entry_q <= left_lt_i ? ins_key_i : left_entry_i;
      end else if (ctrl_i.do_delete) begin
        entry_q <= right_entry_i;
      end
    end
  end

  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

/* rtl/sorted_integer_set.sv */
// A command is taken in the idle state, where the cell row compares against its key; the
// update state then shifts the row and loads the output register, independent of CAPACITY.
// No new command is taken until the update state has finished.
// A result waiting in the output register stalls only the shift cycle.
// Reset clears the count (empty set) and the control state; entries stay undefined.
// Top level of the sorted integer set: cell row, sequencer and result register.
module sorted_integer_set #(
  parameter int unsigned CAPACITY = ssi_pkg::CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssi_in_if.sink      in_i,
  ssi_out_if.source   out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  ssi_pkg::state_e                    state_q, state_d;
  ssi_pkg::cell_ctrl_t                ctrl;
  logic [CntW-1:0]                    count_q, count_d;
  logic [ssi_pkg::CmdW-1:0]           cmd_q;
  logic signed [ssi_pkg::ValueW-1:0]  key_q;

  logic signed [ssi_pkg::ValueW-1:0]  entries [CAPACITY];
  logic [CAPACITY-1:0]                lt_vec;
  logic [CAPACITY-1:0]                eq_vec;

  logic present, full, fire, accept;
  logic is_insert, is_delete;

  logic                               out_valid_q, out_valid_d;
  logic                               present_q;
  logic [ssi_pkg::CountOutW-1:0]      count_out_q;
  logic                               dropped_q;
  logic [CntW+ssi_pkg::CountOutW-1:0] count_ext;

  assign present   = |eq_vec;
  assign full      = count_q == CntW'(CAPACITY);
  assign is_insert = cmd_q == ssi_pkg::CMD_INSERT;
  assign is_delete = cmd_q == ssi_pkg::CMD_DELETE;
  assign accept    = in_i.valid && in_i.ready;

  always_comb begin
    state_d        = state_q;
    in_i.ready     = 1'b0;
    fire           = 1'b0;
    ctrl           = '0;
    count_d        = count_q;
    unique case (state_q)
      ssi_pkg::ST_IDLE: begin
        in_i.ready  = 1'b1;
        ctrl.lookup = in_i.valid;
        if (in_i.valid) begin
          state_d = ssi_pkg::ST_UPDATE;
        end
      end
      ssi_pkg::ST_UPDATE: begin
        fire           = !out_valid_q || out_o.ready;
        ctrl.update    = fire;
        ctrl.do_insert = is_insert && !present && !full;
        ctrl.do_delete = is_delete && present;
        if (fire) begin
          state_d = ssi_pkg::ST_IDLE;
          if (ctrl.do_insert) begin
            count_d = count_q + 1'b1;
          end else if (ctrl.do_delete) begin
            count_d = count_q - 1'b1;
          end
        end
      end
      default: state_d = ssi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssi_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_d = fire || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_i.command;
      key_q <= in_i.item_value;
    end
  end

  assign count_ext = {{ssi_pkg::CountOutW{1'b0}}, count_d};

  always_ff @(posedge clk_i) begin
    if (fire) begin
      present_q   <= present;
      count_out_q <= count_ext[ssi_pkg::CountOutW-1:0];
      dropped_q   <= is_insert && !present && full;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ssi_pkg::ValueW-1:0] left_entry, right_entry;
    logic                              left_lt;

    if (i == 0) begin : g_first
      assign left_entry = entries[i];
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_lt    = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    ssi_cell #(
      .Index (i),
      .CntW  (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .cmp_key_i     (in_i.item_value),
      .ins_key_i     (key_q),
      .left_entry_i  (left_entry),
      .left_lt_i     (left_lt),
      .right_entry_i (right_entry),
      .entry_o       (entries[i]),
      .lt_o          (lt_vec[i]),
      .eq_o          (eq_vec[i])
    );
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.was_present    = present_q;
  assign out_o.element_count  = count_out_q;
  assign out_o.insert_dropped = dropped_q;

endmodule

/* rtl/ssi_checker.sv */
// Port-level checker for the sorted integer set and its bind.
`include "sorted_integer_set_macros.svh"

module ssi_checker #(
  parameter int unsigned CAPACITY = ssi_pkg::CAPACITY
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          was_present_i,
  input logic [ssi_pkg::CountOutW-1:0] element_count_i,
  input logic                          insert_dropped_i
);

  localparam logic [ssi_pkg::CountOutW-1:0] CapLow =
    ssi_pkg::CountOutW'(CAPACITY % 64);
  localparam logic WideCap = CAPACITY >= 64;

  `SSI_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && in_ready_i, !in_ready_i, "ready high in cycle after command transfer")
  `SSI_ASSERT_NEXT(a_result_held, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `SSI_ASSERT_NOW(a_count_bound, out_valid_i, WideCap || (element_count_i <= CapLow), "element count above capacity")
  `SSI_ASSERT_NOW(a_drop_means_full, out_valid_i && insert_dropped_i, !was_present_i && (element_count_i == CapLow), "dropped insert without full set")

endmodule

bind sorted_integer_set ssi_checker #(
  .CAPACITY (CAPACITY)
) u_ssi_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .was_present_i    (out_o.was_present),
  .element_count_i  (out_o.element_count),
  .insert_dropped_i (out_o.insert_dropped)
);

/* tb/sorted_integer_set_checker.sv */
`timescale 1ns / 100ps
// Result checker for the sorted integer set: mirrors the set and compares every result.
module sorted_integer_set_checker #(
  parameter int unsigned CAPACITY = ssi_pkg::CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssi_in_if           cmd_i,
  ssi_out_if          res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned result_count_o,
  output int unsigned present_count_o,
  output int unsigned drop_count_o,
  output int unsigned peak_size_o
);
  import ssi_pkg::*;

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic                 was_present;
    logic [CountOutW-1:0] element_count;
    logic                 insert_dropped;
  } set_result_t;

  logic signed [ValueW-1:0] members[$];
  set_result_t              expected_results[$];
  set_result_t              want;
  set_result_t              got;
  int unsigned              fails;
  int unsigned              results;
  int unsigned              hits;
  int unsigned              drops;
  int unsigned              peak;

  assign fail_count_o    = fails;
  assign result_count_o  = results;
  assign present_count_o = hits;
  assign drop_count_o    = drops;
  assign peak_size_o     = peak;

  function automatic set_result_t apply_command(logic [CmdW-1:0] cmd,
                                                logic signed [ValueW-1:0] value);
    int unsigned pos;
    logic        found;
    set_result_t res;
    pos = 0;
    while (pos < members.size() && members[pos] < value) pos++;
    found = (pos < members.size()) && (members[pos] == value);
    res = '0;
    res.was_present = found;
    case (cmd)
      CMD_INSERT: begin
        if (!found) begin
          if (members.size() >= CAPACITY) res.insert_dropped = 1'b1;
          else members.insert(pos, value);
        end
      end
      CMD_DELETE: begin
        if (found) members.delete(pos);
      end
      default: ;
    endcase
    res.element_count = CountOutW'(members.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      members.delete();
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cmd_i.valid && cmd_i.ready) begin
        expected_results.push_back(apply_command(cmd_i.command, cmd_i.item_value));
        if (members.size() > peak) peak = members.size();
      end
      if (res_i.valid && res_i.ready) begin
        got.was_present    = res_i.was_present;
        got.element_count  = res_i.element_count;
        got.insert_dropped = res_i.insert_dropped;
        results++;
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= ReportLimit)
            $display("result %0d with none outstanding: present=%0b count=%0d dropped=%0b",
                     results, got.was_present, got.element_count, got.insert_dropped);
        end else begin
          want = expected_results.pop_front();
          if (want.was_present) hits++;
          if (want.insert_dropped) drops++;
          if (got.was_present !== want.was_present ||
              got.element_count !== want.element_count ||
              got.insert_dropped !== want.insert_dropped) begin
            fails++;
            if (fails <= ReportLimit)
              $display("result %0d: expected present=%0b count=%0d dropped=%0b, got present=%0b count=%0d dropped=%0b",
                       results, want.was_present, want.element_count, want.insert_dropped,
                       got.was_present, got.element_count, got.insert_dropped);
          end
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

/* tb/sorted_integer_set_test.sv */
`timescale 1ns / 100ps
// Top of the sorted integer set testbench: clock, reset, command stimulus, result back-pressure and verdict.
module sorted_integer_set_test;
  import ssi_pkg::*;

  localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned PoolSize    = 48;
  localparam int unsigned PhaseCount  = 10;
  localparam int unsigned PhaseItems  = 193;
  localparam int unsigned HoldPhase   = 1;
  localparam int unsigned HoldItem    = 40;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 1000000;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  logic        clk_i;
  logic        rst_ni;
  bit          calm;
  bit          hold_req;
  int unsigned holds_done;
  int unsigned sent;
  int unsigned cycles;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_count;
  int unsigned present_count;
  int unsigned drop_count;
  int unsigned peak_size;

  logic signed [ValueW-1:0] value_pool [PoolSize];

  ssi_in_if  in_if ();
  ssi_out_if out_if ();

  sorted_integer_set u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sorted_integer_set_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (in_if),
    .res_i           (out_if),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .result_count_o  (result_count),
    .present_count_o (present_count),
    .drop_count_o    (drop_count),
    .peak_size_o     (peak_size)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("sorted_integer_set_test NOT OK");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned r;
    int unsigned idx;
    r = $urandom_range(0, 99);
    idx = $urandom_range(0, PoolSize - 1);
    if (r < 70) return value_pool[idx];
    if (r < 80) return $urandom_range(0, 1) ? value_pool[idx] + 32'sd1
                                            : value_pool[idx] - 32'sd1;
    return $urandom();
  endfunction

  function automatic logic [CmdW-1:0] pick_command(mix_e mix);
    int unsigned r;
    int unsigned ins_bound;
    int unsigned del_bound;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        ins_bound = 65;
        del_bound = 80;
      end
      MIX_DRAIN: begin
        ins_bound = 15;
        del_bound = 75;
      end
      default: begin
        ins_bound = 40;
        del_bound = 75;
      end
    endcase
    if (r < ins_bound) return CMD_INSERT;
    if (r < del_bound) return CMD_DELETE;
    if (r < 96) return CMD_QUERY;
    return CMD_SPARE;
  endfunction

  task automatic send_item(logic [CmdW-1:0] cmd, logic signed [ValueW-1:0] value);
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.item_value <= value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && holds_done == 0) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        holds_done++;
      end else if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 25) stall_left = idle_len() + 1;
      end
    end
  end

  initial begin : stimulus
    mix_e mix;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_QUERY;
    in_if.item_value <= '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    for (int i = 0; i < PoolSize; i++) value_pool[i] = $urandom();
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < 12; i++) value_pool[i] = $urandom_range(0, 20) - 10;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CMD_QUERY,  32'sh7fff_ffff);
    send_item(CMD_DELETE, 32'sd0);
    send_item(CMD_INSERT, 32'sd0);
    send_item(CMD_INSERT, 32'sh8000_0000);
    send_item(CMD_INSERT, 32'sh7fff_ffff);
    send_item(CMD_INSERT, -32'sd1);
    send_item(CMD_INSERT, 32'sd1);
    send_item(CMD_INSERT, 32'sd0);
    send_item(CMD_QUERY,  -32'sd1);
    send_item(CMD_QUERY,  32'sd2);
    send_item(CMD_SPARE,  32'sh8000_0000);
    send_item(CMD_SPARE,  32'sd5);
    send_item(CMD_DELETE, 32'sd5);
    send_item(CMD_DELETE, 32'sh8000_0000);
    send_item(CMD_DELETE, 32'sh7fff_ffff);
    send_item(CMD_DELETE, 32'sd0);
    send_item(CMD_INSERT, 32'sh5555_5555);
    send_item(CMD_INSERT, 32'shaaaa_aaaa);
    send_item(CMD_QUERY,  32'shaaaa_aaaa);
    send_item(CMD_DELETE, -32'sd1);
    send_item(CMD_DELETE, 32'sd1);
    send_item(CMD_DELETE, 32'sh5555_5555);
    send_item(CMD_DELETE, 32'shaaaa_aaaa);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase % 3)
        0:       mix = MIX_FILL;
        1:       mix = MIX_DRAIN;
        default: mix = MIX_EVEN;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == HoldPhase && n == HoldItem) hold_req = 1'b1;
        send_item(pick_command(mix), pick_value());
      end
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d commands sent, %0d results checked: %0d hit an existing value, %0d inserts refused on a full set",
             sent, result_count, present_count, drop_count);
    $display("set grew to %0d of %0d entries; %0d output hold of %0d cycles backed up the input",
             peak_size, CAPACITY, holds_done, HoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_integer_set_test OK");
    end else begin
      $display("sorted_integer_set_test NOT OK");
    end
    $finish;
  end

endmodule
